/* src/lsae_pkg.sv */
package lsae_pkg;

	// Animation modes, as held in the animation_mode register
	typedef enum logic [1:0] {
		MODE_BREATHE = 2'd0,
		MODE_ROTATE  = 2'd1,
		MODE_SOLID   = 2'd2,
		MODE_WAVE    = 2'd3
	} anim_mode_t;

	// Pointer modes carried by each tick
	localparam logic [1:0] PTR_SCROLL = 2'd1;
	localparam logic [1:0] PTR_MIDDLE = 2'd2;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;
	localparam logic [CFG_INDEX_W-1:0] REG_ANIM_MODE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_MS  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_COLOR = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MIDDLE_COLOR = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MOUSE_COLOR  = 3'd4;

	localparam logic [15:0] INTERVAL_RESET = 16'd75;

	// Phase steps in 1/65536 of a turn
	localparam logic [15:0] BREATHE_STEP = 16'd522;
	localparam logic [15:0] WAVE_STEP    = 16'd1043;
	localparam logic [15:0] WAVE_OFFSET  = 16'd5215;

	// Quarter-wave sine polynomial in Q30 (odd, degree nine)
	localparam longint Q30     = 64'sd1073741824;
	localparam longint POLY_C0 = 64'sd1686629713;
	localparam longint POLY_C1 = -64'sd693598668;
	localparam longint POLY_C2 = 64'sd85569306;
	localparam longint POLY_C3 = -64'sd5026995;
	localparam longint POLY_C4 = 64'sd172272;

	// One frame job handed from the tick gate to the frame pipeline
	typedef struct packed {
		logic [23:0] color;
		anim_mode_t  mode;
		logic [15:0] phase;
		logic [5:0]  lit;
	} job_t;

	// One LED result
	typedef struct packed {
		logic [5:0] led_number;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} pixel_t;

endpackage

/* src/led_strip_animation_engine.sv */
// The first LED result of an updating tick passes the job registers, stages s1 and s2
// and the output register. Throughput: one LED result per cycle unless m_tready stalls,
// STRIP_LENGTH per updating tick; gate-dropped ticks are taken one per cycle while the frame pipeline has room.
// A new tick is taken in the cycle the previous frame issues its last LED.
// Reset (arst_n low): registers return to their defaults, state clears, pipeline empties.
module led_strip_animation_engine #(
	parameter int STRIP_LENGTH = 8,
	parameter int SINE_ENTRIES = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [39:0]                        s_tdata,  // now_ms[31:0], pointer_mode[33:32]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [31:0]                        m_tdata,  // led_number[5:0], red[13:6],
	                                                     // green[21:14], blue[29:22]
	output logic                               m_tlast,  // frame_end
	input  logic                               cfg_we,
	input  logic [lsae_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lsae_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lsae_pkg::*;

	localparam logic [5:0] LAST_LED = 6'(STRIP_LENGTH - 1);

	// Configuration registers
	anim_mode_t  anim_mode_q;
	logic [15:0] interval_q;
	logic [23:0] scroll_color_q;
	logic [23:0] middle_color_q;
	logic [23:0] mouse_color_q;

	// Animation state
	logic [31:0] last_update_q;
	logic [15:0] phase_q;
	logic [5:0]  lit_q;

	logic [31:0] now_ms;
	logic [1:0]  pointer_mode;
	logic [31:0] elapsed;
	logic        take, emit, load_ok;
	job_t        job;
	pixel_t      pix;

	assign now_ms       = s_tdata[31:0];
	assign pointer_mode = s_tdata[33:32];

	// Hold configuration; writes beyond the register list drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anim_mode_q    <= MODE_BREATHE;
			interval_q     <= INTERVAL_RESET;
			scroll_color_q <= '0;
			middle_color_q <= '0;
			mouse_color_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANIM_MODE:    anim_mode_q    <= anim_mode_t'(cfg_data[1:0]);
				REG_INTERVAL_MS:  interval_q     <= cfg_data[15:0];
				REG_SCROLL_COLOR: scroll_color_q <= cfg_data;
				REG_MIDDLE_COLOR: middle_color_q <= cfg_data;
				REG_MOUSE_COLOR:  mouse_color_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take a tick only when the frame pipeline can load a new job
	assign s_tready = load_ok;
	assign take     = s_tvalid && s_tready;

	// Gate: solid always updates; other modes wait out the interval (mod 2^32)
	assign elapsed = now_ms - last_update_q;
	assign emit    = (anim_mode_q == MODE_SOLID) || (elapsed >= {16'd0, interval_q});

	// Pick the base color from the pointer mode; phase and lit position are pre-update
	always_comb begin
		case (pointer_mode)
			PTR_SCROLL: job.color = scroll_color_q;
			PTR_MIDDLE: job.color = middle_color_q;
			default:    job.color = mouse_color_q;
		endcase
		job.mode  = anim_mode_q;
		job.phase = phase_q;
		job.lit   = lit_q;
	end

	// Advance animation state on every gated update; solid leaves it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_update_q <= '0;
			phase_q       <= '0;
			lit_q         <= '0;
		end else if (take && emit && anim_mode_q != MODE_SOLID) begin
			last_update_q <= now_ms;
			case (anim_mode_q)
				MODE_BREATHE: phase_q <= phase_q + BREATHE_STEP;
				MODE_WAVE:    phase_q <= phase_q + WAVE_STEP;
				MODE_ROTATE:  lit_q   <= (lit_q >= LAST_LED) ? 6'd0 : lit_q + 6'd1;
				default: ;
			endcase
		end
	end

	lsae_frame_pipe #(
		.STRIP_LENGTH(STRIP_LENGTH),
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_frame_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (take && emit),
		.job       (job),
		.load_ok   (load_ok),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (pix)
	);

	assign m_tdata = {2'b00, pix.blue, pix.green, pix.red, pix.led_number};
	assign m_tlast = pix.frame_end;

	// A solid-mode tick never moves the update timestamp
	a_solid_keeps_time: assert property (@(posedge clk) disable iff (!arst_n)
		take && anim_mode_q == MODE_SOLID |=> $stable(last_update_q))
		else $error("solid tick changed last update time");

	// The rotating LED always stays on the strip
	a_lit_on_strip: assert property (@(posedge clk) disable iff (!arst_n)
		lit_q <= LAST_LED)
		else $error("lit position left the strip");

	// The frame end mark rides only on the last LED
	a_last_on_last_led: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[5:0] == LAST_LED)))
		else $error("frame end on wrong LED");

	// Without a taken tick the timestamp stays put
	a_drop_keeps_time: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(last_update_q))
		else $error("timestamp moved without a tick");

endmodule

/* src/lsae_frame_pipe.sv */
module lsae_frame_pipe #(
	parameter int STRIP_LENGTH = 8,
	parameter int SINE_ENTRIES = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lsae_pkg::job_t  job,
	output logic            load_ok,
	output logic            out_valid,
	input  logic            out_ready,
	output lsae_pkg::pixel_t out_pix
);
	import lsae_pkg::*;

	localparam int IW = (SINE_ENTRIES > 1) ? $clog2(SINE_ENTRIES) : 1;
	localparam int PW = 16 + IW;
	localparam logic [5:0] LAST_LED = 6'(STRIP_LENGTH - 1);

	// k = scale factor for sine index idx, evaluated at elaboration
	function automatic logic [7:0] scale_k(input int idx);
		longint u;
		longint q;
		longint r;
		longint x;
		longint x2;
		longint acc;
		longint lvl;
		longint k;
		u = (longint'(idx) * 64'sd65536) / SINE_ENTRIES;
		q = (u >>> 14) & 64'sd3;
		r = u & 64'sd16383;
		if (q[0]) r = 64'sd16384 - r;
		x = r * 64'sd65536;
		x2 = (x * x) / Q30;
		acc = POLY_C4;
		acc = POLY_C3 + (acc * x2) / Q30;
		acc = POLY_C2 + (acc * x2) / Q30;
		acc = POLY_C1 + (acc * x2) / Q30;
		acc = POLY_C0 + (acc * x2) / Q30;
		acc = (acc * x) / Q30;
		if (acc < 0) acc = 0;
		if (acc > Q30) acc = Q30;
		lvl = (q < 2) ? (Q30 + acc) : (Q30 - acc);
		k = (lvl * 64'sd255 + Q30) >>> 31;
		if (k > 255) k = 255;
		return k[7:0];
	endfunction

	logic [7:0] ktab [SINE_ENTRIES];
	for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_ktab
		assign ktab[g] = scale_k(g);
	end

	// Job registers
	logic        active_q;
	logic [5:0]  cnt_q;
	logic [15:0] turn_q;
	logic [23:0] color_q;
	anim_mode_t  mode_q;
	logic [5:0]  lit_q;

	// Stage registers
	logic          valid_s1, valid_s2, valid_q;
	logic [5:0]    led_s1, led_s2;
	logic          last_s1, last_s2;
	logic [23:0]   color_s1, color_s2;
	logic          scaled_s1, scaled_s2;
	logic [IW-1:0] idx_s1;
	logic [7:0]    k_s2;
	pixel_t        pix_q;

	logic          adv, issue, is_last;
	logic [PW-1:0] prod;
	logic [15:0]   r_p, g_p, b_p;

	assign adv     = !valid_q || out_ready;
	assign issue   = adv && active_q;
	assign is_last = (cnt_q == LAST_LED);
	assign load_ok = !active_q || (issue && is_last);
	assign prod    = PW'(turn_q) * PW'(SINE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (start) begin
			active_q <= 1'b1;
		end else if (issue && is_last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q   <= '0;
			turn_q  <= job.phase;
			color_q <= job.color;
			mode_q  <= job.mode;
			lit_q   <= job.lit;
		end else if (issue) begin
			cnt_q <= cnt_q + 6'd1;
			if (mode_q == MODE_WAVE) turn_q <= turn_q + WAVE_OFFSET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			led_s1    <= cnt_q;
			last_s1   <= is_last;
			color_s1  <= (mode_q == MODE_ROTATE && cnt_q != lit_q) ? 24'd0 : color_q;
			scaled_s1 <= (mode_q == MODE_BREATHE) || (mode_q == MODE_WAVE);
			idx_s1    <= prod[16 +: IW];

			led_s2    <= led_s1;
			last_s2   <= last_s1;
			color_s2  <= color_s1;
			scaled_s2 <= scaled_s1;
			k_s2      <= ktab[idx_s1];

			pix_q.led_number <= led_s2;
			pix_q.frame_end  <= last_s2;
			pix_q.red        <= scaled_s2 ? r_p[15:8] : color_s2[23:16];
			pix_q.green      <= scaled_s2 ? g_p[15:8] : color_s2[15:8];
			pix_q.blue       <= scaled_s2 ? b_p[15:8] : color_s2[7:0];
		end
	end

	assign r_p = color_s2[23:16] * k_s2;
	assign g_p = color_s2[15:8] * k_s2;
	assign b_p = color_s2[7:0] * k_s2;

	assign out_valid = valid_q;
	assign out_pix   = pix_q;

endmodule
